[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication whose consequence is checked in the cycle after the condition
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

[rtl/ilir_pkg.sv]
package ilir_pkg;

    localparam int CAPACITY_DEFAULT  = 64;
    localparam int WORD_BITS_DEFAULT = 32;

    localparam int OP_BITS     = 2;
    localparam int POS_BITS    = 6;
    localparam int VALUE_BITS  = 32;
    localparam int LENGTH_BITS = 7;
    localparam int STATUS_BITS = 2;
    localparam int EXT_BITS    = 64;

    typedef enum logic [OP_BITS-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_GET    = 2'd3
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // command broadcast to every cell
    typedef struct packed {
        logic insert_en;
        logic remove_en;
    } cell_cmd_t;

endpackage

[rtl/ilir_if.sv]
interface ilir_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [5:0]         position;
    logic signed [31:0] data_value;

    modport source (output valid, output operation, output position, output data_value,
                    input ready);
    modport sink   (input valid, input operation, input position, input data_value,
                    output ready);
endinterface

interface ilir_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    logic [6:0]         list_length;
    logic [1:0]         status;

    modport source (output valid, output read_value, output list_length, output status,
                    input ready);
    modport sink   (input valid, input read_value, input list_length, input status,
                    output ready);
endinterface

[rtl/ilir_cell.sv]
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int INDEX     = 0,
    parameter int CNT_BITS  = 7,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  cell_cmd_t            cmd,
    input  logic [CNT_BITS-1:0]  wr_pos,
    input  logic [CNT_BITS-1:0]  rd_pos,
    input  logic [WORD_BITS-1:0] data_in,
    input  logic [WORD_BITS-1:0] left_word,
    input  logic [WORD_BITS-1:0] right_word,
    output logic [WORD_BITS-1:0] word,
    output logic [WORD_BITS-1:0] tap
);

    localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (cmd.insert_en)
        begin
            if (MY_INDEX == wr_pos)
            begin
                word_next = data_in;
            end
            else if (MY_INDEX > wr_pos)
            begin
                word_next = left_word;
            end
        end
        else if (cmd.remove_en)
        begin
            if (MY_INDEX >= rd_pos)
            begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;
    assign tap  = (MY_INDEX == rd_pos) ? word_reg : '0;

endmodule

[rtl/indexed_list_insert_remove.sv]
// an accepted request has its response in the output register in the next cycle
// throughput: one request per cycle while the response side keeps taking results
// every cell that shifts moves its word in the same cycle, so insert and remove are no slower than get
// reset: list length and output valid cleared at once; stored words keep no reset
// value and are never read before they are written
`include "assert_macros.svh"

module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY  = CAPACITY_DEFAULT,
    parameter int WORD_BITS = WORD_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    ilir_req_if.sink    req,
    ilir_rsp_if.source  rsp
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);
    localparam int CMP_BITS = CNT_BITS + POS_BITS;
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(CAPACITY);

    // request side
    logic                   accept;
    op_t                    op;
    logic [CMP_BITS-1:0]    pos_wide;
    logic [CMP_BITS-1:0]    count_wide;
    logic [CNT_BITS-1:0]    pos_short;
    logic [EXT_BITS-1:0]    data_ext;
    logic [WORD_BITS-1:0]   data_word;

    // list state
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;

    // cell row
    cell_cmd_t              cmd;
    logic [CNT_BITS-1:0]    wr_pos;
    logic [WORD_BITS-1:0]   cell_word [CAPACITY];
    logic [WORD_BITS-1:0]   cell_tap  [CAPACITY];
    logic [WORD_BITS-1:0]   rd_word;
    logic [EXT_BITS-1:0]    rd_ext;

    // response computed in the accepting cycle
    status_t                status_next;
    logic [VALUE_BITS-1:0]  value_next;
    logic [LENGTH_BITS+CNT_BITS-1:0] length_wide;

    // output register
    logic                   out_valid_reg;
    logic [VALUE_BITS-1:0]  out_value_reg;
    logic [LENGTH_BITS-1:0] out_length_reg;
    status_t                out_status_reg;

    // a new request is taken whenever the output register is free or being emptied
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign op = op_t'(req.operation);

    // position and length compared at a common width so no value aliases
    assign pos_wide   = {{CNT_BITS{1'b0}}, req.position};
    assign count_wide = {{POS_BITS{1'b0}}, count_reg};
    assign pos_short  = pos_wide[CNT_BITS-1:0];

    // input word sign-extended from its field and cut to the stored width
    assign data_ext  = EXT_BITS'(req.data_value);
    assign data_word = data_ext[WORD_BITS-1:0];

    // word at the requested position, gathered from the one cell that matches
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_word = rd_word | cell_tap[i];
        end
    end

    // stored word sign-extended from its width and cut to the result field
    assign rd_ext = EXT_BITS'($signed(rd_word));

    // request decode: status, read value, new length and the command for the cell row
    always_comb
    begin
        status_next = ST_DONE;
        value_next  = '0;
        count_next  = count_reg;
        cmd         = '0;
        wr_pos      = pos_short;
        case (op)
            OP_APPEND:
            begin
                wr_pos = count_reg;
                if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.insert_en = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else if (pos_wide > count_wide)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.insert_en = accept;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (pos_wide >= count_wide)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    cmd.remove_en = accept;
                    value_next    = rd_ext[VALUE_BITS-1:0];
                    count_next    = count_reg - 1'b1;
                end
            end
            OP_GET:
            begin
                if (pos_wide >= count_wide)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    value_next = rd_ext[VALUE_BITS-1:0];
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    // row of cells: those past the insert position take their left neighbour, from the remove position their right
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : gen_cell
            logic [WORD_BITS-1:0] left_word;
            logic [WORD_BITS-1:0] right_word;

            if (g == 0)
            begin : gen_first
                assign left_word = '0;
            end
            else
            begin : gen_left
                assign left_word = cell_word[g-1];
            end

            if (g == CAPACITY - 1)
            begin : gen_last
                assign right_word = '0;
            end
            else
            begin : gen_right
                assign right_word = cell_word[g+1];
            end

            ilir_cell #(
                .INDEX     (g),
                .CNT_BITS  (CNT_BITS),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .wr_pos     (wr_pos),
                .rd_pos     (pos_short),
                .data_in    (data_word),
                .left_word  (left_word),
                .right_word (right_word),
                .word       (cell_word[g]),
                .tap        (cell_tap[g])
            );
        end
    endgenerate

    // list length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // length field of the response, widened or cut to seven bits
    assign length_wide = {{LENGTH_BITS{1'b0}}, count_next};

    // output register: holds the response until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg  <= value_next;
            out_length_reg <= length_wide[LENGTH_BITS-1:0];
            out_status_reg <= status_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_value_reg;
    assign rsp.list_length = out_length_reg;
    assign rsp.status      = out_status_reg;

    // length never passes the capacity
    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_COUNT, "list length above capacity")

    // a completed append or insert grows the list by exactly one
    `ASSERT_NEXT(a_grow, accept && status_next == ST_DONE && (op == OP_APPEND || op == OP_INSERT), count_reg == CNT_BITS'($past(count_reg) + 1'b1), "list did not grow by one")

    // a refused request leaves the length alone
    `ASSERT_NEXT(a_refused_keeps, accept && status_next != ST_DONE, $stable(count_reg), "refused request changed the length")

    // a full refusal only when the list is full
    `ASSERT_IMPLIES(a_full_only, accept && status_next == ST_FULL, count_reg == FULL_COUNT, "full status on a list with room")

endmodule
